>>> hw/rtl/pidsc_pkg.sv
// ---------------------------------------------------------------------------
// pidsc_pkg: shared definitions for the PID speed controller
// Field widths, register indexes and the constants of the integral divider.
// ---------------------------------------------------------------------------
`default_nettype none

package pidsc_pkg;

   localparam int SPEED_W   = 16;  // target and measured speed
   localparam int GAIN_W    = 7;   // each gain register
   localparam int PWM_W     = 11;  // drive command
   localparam int SUM_W     = 40;  // integrator
   localparam int CSR_IDX_W = 2;

   localparam int REQ_DATA_W = 2 * SPEED_W;
   localparam int RSP_DATA_W = 16;

   localparam int PWM_LIMIT = 1000;

   // integrator saturates at +/-(2^39 - 1)
   localparam logic signed [SUM_W:0] SUM_HI = 41'sd549755813887;
   localparam logic signed [SUM_W:0] SUM_LO = -41'sd549755813887;

   // divide by 1000 as a shift by 3 and a divide by 125
   localparam int DIV_PRE_SHIFT = 3;
   localparam int DIV_STEP      = 125;
   localparam int RECIP_W       = 26;
   localparam logic [RECIP_W-1:0] RECIP_125 = 26'd34359738;  // floor(2^32 / 125)

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_P = 2'd0,
      CSR_GAIN_I = 2'd1,
      CSR_GAIN_D = 2'd2
   } csr_index_type;

endpackage

`default_nettype wire

>>> hw/rtl/pid_speed_controller_top.sv
// ---------------------------------------------------------------------------
// pid_speed_controller_top: discrete PID speed loop for a drive motor
// One beat per control tick: error, saturating integrator, P + I + D, halved
// and clamped to +/-1000.
//
//   channel  dir  handshake                 payload
//   req_     in   req_tvalid / req_tready   req_tdata: target, measured speed
//   rsp_     out  rsp_tvalid / rsp_tready   rsp_tdata: drive_pwm
//   csr_     in   csr_valid / csr_ready     csr_index, csr_data: gains
//
// One beat per cycle is accepted unless the output stalls; results pass stages 1-3.
// Latency is set by the integral path: gain multiply, reciprocal multiply for
// the divide by 1000, then correction and final sum.
// Integrator, previous error and previous target update at the accepted beat.
// Each stage holds while the next is full and stalled; csr_ready is always high.
// Synchronous reset clears the gains, the loop state and all stage valids.
// ---------------------------------------------------------------------------
`default_nettype none

module pid_speed_controller_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   // [15:0] target_speed, [31:16] measured_speed
   input  wire logic [pidsc_pkg::REQ_DATA_W-1:0]   req_tdata,
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [10:0] drive_pwm, [15:11] zero
   output      logic [pidsc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  wire logic                               csr_valid,
   output      logic                               csr_ready,
   input  wire logic [pidsc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [pidsc_pkg::GAIN_W-1:0]       csr_data
);
   import pidsc_pkg::*;

   // configuration
   logic [GAIN_W-1:0] kp_ff, ki_ff, kd_ff;

   // loop state
   logic signed [SUM_W-1:0]   error_sum_ff, error_sum_in;
   logic signed [SPEED_W-1:0] last_error_ff;
   logic [SPEED_W-1:0]        last_target_ff;

   // stage valids
   logic v1_ff, v2_ff, v3_ff, vo_ff;
   logic rdy1, rdy2, rdy3, rdyo, accept;

   // stage 1
   logic signed [SUM_W-1:0] sum1_ff;
   logic signed [24:0]      p1_ff, p1_in;
   logic signed [25:0]      d1_ff, d1_in;
   // stage 2
   logic signed [46:0]      prod2_ff, prod2_in;
   logic signed [25:0]      pd2_ff, pd2_in;
   // stage 3
   logic                    neg3_ff, neg3_in;
   logic [31:0]             m3_ff, m3_in;
   logic [RECIP_W-1:0]      q3_ff, q3_in;
   logic signed [25:0]      pd3_ff;
   // output
   logic [PWM_W-1:0]        pwm_ff, pwm_in;

   // ---------------- handshakes ----------------
   assign rdyo       = !vo_ff || rsp_tready;
   assign rdy3       = !v3_ff || rdyo;
   assign rdy2       = !v2_ff || rdy3;
   assign rdy1       = !v1_ff || rdy2;
   assign req_tready = rdy1;
   assign accept     = req_tvalid && rdy1;
   assign csr_ready  = 1'b1;

   // ---------------- stage 0: error, integrator, P and D ----------------
   logic signed [SPEED_W-1:0] tgt, meas;
   logic signed [SPEED_W:0]   err;
   logic signed [SPEED_W+1:0] diff;
   logic signed [SUM_W-1:0]   sum_base;
   logic signed [SUM_W:0]     sum_raw;

   always_comb begin
      tgt      = $signed(req_tdata[SPEED_W-1:0]);
      meas     = $signed(req_tdata[2*SPEED_W-1:SPEED_W]);
      err      = {tgt[SPEED_W-1], tgt} - {meas[SPEED_W-1], meas};
      // restart the integral on a new target
      sum_base = (req_tdata[SPEED_W-1:0] != last_target_ff) ? '0 : error_sum_ff;
      sum_raw  = {sum_base[SUM_W-1], sum_base} + {{(SUM_W-SPEED_W){err[SPEED_W]}}, err};
      if (sum_raw > SUM_HI) begin
         error_sum_in = SUM_HI[SUM_W-1:0];
      end else if (sum_raw < SUM_LO) begin
         error_sum_in = SUM_LO[SUM_W-1:0];
      end else begin
         error_sum_in = sum_raw[SUM_W-1:0];
      end
      diff  = {err[SPEED_W], err} - {{2{last_error_ff[SPEED_W-1]}}, last_error_ff};
      p1_in = $signed({1'b0, kp_ff}) * err;
      d1_in = $signed({1'b0, kd_ff}) * diff;
   end

   // ---------------- stage 1 -> 2: integral gain ----------------
   always_comb begin
      prod2_in = $signed({1'b0, ki_ff}) * sum1_ff;
      pd2_in   = {p1_ff[24], p1_ff} + d1_ff;
   end

   // ---------------- stage 2 -> 3: magnitude / 1000 estimate ----------------
   logic [46:0]         mag;
   logic [34:0]         mag_sat;
   logic [RECIP_W+31:0] qprod;

   always_comb begin
      neg3_in = prod2_ff[46];
      mag     = neg3_in ? 47'(-prod2_ff) : 47'(prod2_ff);
      // beyond 2^35 the output is saturated anyway
      mag_sat = (|mag[46:35]) ? '1 : mag[34:0];
      m3_in   = mag_sat[34:DIV_PRE_SHIFT];
      qprod   = (RECIP_W+32)'(m3_in) * (RECIP_W+32)'(RECIP_125);
      q3_in   = qprod[RECIP_W+31:32];
   end

   // ---------------- stage 3 -> out: correct, sum, halve, clamp ----------------
   logic [32:0]        qmul, rem;
   logic [RECIP_W:0]   q_fix;
   logic signed [26:0] i_term, total;
   logic signed [25:0] half;

   always_comb begin
      qmul   = 33'(q3_ff) * 33'(DIV_STEP);
      rem    = {1'b0, m3_ff} - qmul;
      // estimate is low by at most one
      q_fix  = {1'b0, q3_ff} +
               ((rem >= 33'(DIV_STEP)) ? (RECIP_W+1)'(1) : (RECIP_W+1)'(0));
      i_term = neg3_ff ? -$signed(q_fix) : $signed(q_fix);
      total  = {pd3_ff[25], pd3_ff} + i_term;
      half   = total[26:1];
      if (half > 26'(PWM_LIMIT)) begin
         pwm_in = PWM_W'(PWM_LIMIT);
      end else if (half < -26'(PWM_LIMIT)) begin
         pwm_in = PWM_W'(-PWM_LIMIT);
      end else begin
         pwm_in = half[PWM_W-1:0];
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff          <= '0;
         ki_ff          <= '0;
         kd_ff          <= '0;
         error_sum_ff   <= '0;
         last_error_ff  <= '0;
         last_target_ff <= '0;
         v1_ff          <= 1'b0;
         v2_ff          <= 1'b0;
         v3_ff          <= 1'b0;
         vo_ff          <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_GAIN_P: kp_ff <= csr_data;
               CSR_GAIN_I: ki_ff <= csr_data;
               CSR_GAIN_D: kd_ff <= csr_data;
               default: ;
            endcase
         end
         if (accept) begin
            error_sum_ff   <= error_sum_in;
            last_error_ff  <= err[SPEED_W-1:0];
            last_target_ff <= req_tdata[SPEED_W-1:0];
         end
         if (rdy1) v1_ff <= req_tvalid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdyo) vo_ff <= v3_ff;
      end
   end

   // payload: advance with each stage, no reset
   always_ff @(posedge clock) begin
      if (rdy1) begin
         sum1_ff <= error_sum_in;
         p1_ff   <= p1_in;
         d1_ff   <= d1_in;
      end
      if (rdy2) begin
         prod2_ff <= prod2_in;
         pd2_ff   <= pd2_in;
      end
      if (rdy3) begin
         neg3_ff <= neg3_in;
         m3_ff   <= m3_in;
         q3_ff   <= q3_in;
         pd3_ff  <= pd2_ff;
      end
      if (rdyo) begin
         pwm_ff <= pwm_in;
      end
   end

   assign rsp_tvalid = vo_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-PWM_W){1'b0}}, pwm_ff};

   // ---------------- assertions ----------------
   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      ($signed({error_sum_ff[SUM_W-1], error_sum_ff}) <= SUM_HI) &&
      ($signed({error_sum_ff[SUM_W-1], error_sum_ff}) >= SUM_LO))
      else $error("integrator outside saturation limits");

   a_pwm_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(pwm_ff) <= $signed(PWM_W'(PWM_LIMIT))) &&
                     ($signed(pwm_ff) >= $signed(PWM_W'(-PWM_LIMIT))))
      else $error("drive command outside clamp range");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      accept |=> v1_ff)
      else $error("accepted beat did not enter the pipeline");

endmodule

`default_nettype wire

>>> bench/pid_speed_controller_top_tb.sv
// ---------------------------------------------------------------------------
// pid_speed_controller_top_tb: self-checking bench for the PID speed loop
// Drives control ticks on the request stream and gain writes on the CSR
// channel. It tracks the integrator, previous error and previous target in a
// local predictor and compares every drive command with the oldest pending
// prediction. Both stream sides idle at random, and the response side holds
// off once for a long stretch to fill the pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

module pid_speed_controller_top_tb;
   import pidsc_pkg::*;

   localparam int     IDLE_LIMIT       = 2000;  // cycles with no beat on any channel
   localparam int     SETTLE_CYCLES    = 8;     // pipeline is four stages deep
   localparam int     LONG_HOLD_CYCLES = 300;
   localparam longint INTEG_LIMIT      = 64'sd549755813887;
   localparam longint INTEG_SCALE      = 1000;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      logic [SPEED_W-1:0] target;
      logic [SPEED_W-1:0] measured;
      logic [PWM_W-1:0]   pwm;
   } tick_result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   wire                   req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // [15:0] target, [31:16] measured
   wire                   rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   wire  [RSP_DATA_W-1:0] rsp_tdata;        // [10:0] drive_pwm, [15:11] zero
   logic                  csr_valid  = 1'b0;
   wire                   csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [GAIN_W-1:0]     csr_data   = '0;

   pid_speed_controller_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // loop state and gains as the block should hold them
   logic [GAIN_W-1:0]  kp_gain = '0;
   logic [GAIN_W-1:0]  ki_gain = '0;
   logic [GAIN_W-1:0]  kd_gain = '0;
   longint             integ_sum   = 0;
   logic [SPEED_W-1:0] prev_error  = '0;
   logic [SPEED_W-1:0] prev_target = '0;

   tick_result_type pwm_expected[$];

   int  error_count     = 0;
   int  ticks_sent      = 0;
   int  results_checked = 0;
   int  gain_settings   = 0;
   int  long_hold_ask   = 0;
   bit  src_steady      = 1'b0;

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      else if (r < 88) return $urandom_range(1, 3);
      else if (r < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   // one control tick: advance the loop state and return the drive command
   function automatic logic [PWM_W-1:0] next_drive_pwm(logic [SPEED_W-1:0] target,
                                                       logic [SPEED_W-1:0] measured);
      longint err;
      longint diff;
      longint total;
      longint half;
      err = longint'($signed(target)) - longint'($signed(measured));
      if (target != prev_target) integ_sum = 0;
      integ_sum = integ_sum + err;
      if (integ_sum > INTEG_LIMIT) integ_sum = INTEG_LIMIT;
      if (integ_sum < -INTEG_LIMIT) integ_sum = -INTEG_LIMIT;
      diff  = err - longint'($signed(prev_error));
      total = longint'(kp_gain) * err
            + (longint'(ki_gain) * integ_sum) / INTEG_SCALE
            + longint'(kd_gain) * diff;
      half = total >>> 1;
      if (half > PWM_LIMIT) half = PWM_LIMIT;
      if (half < -PWM_LIMIT) half = -PWM_LIMIT;
      prev_error  = err[SPEED_W-1:0];
      prev_target = target;
      return half[PWM_W-1:0];
   endfunction

   task automatic send_tick(logic [SPEED_W-1:0] target, logic [SPEED_W-1:0] measured);
      int              gap;
      tick_result_type entry;
      gap = src_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {measured, target};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      entry.target   = target;
      entry.measured = measured;
      entry.pwm      = next_drive_pwm(target, measured);
      pwm_expected.push_back(entry);
      ticks_sent++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pwm_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_gain(logic [CSR_IDX_W-1:0] index, logic [GAIN_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         CSR_GAIN_P: kp_gain = value;
         CSR_GAIN_I: ki_gain = value;
         CSR_GAIN_D: kd_gain = value;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_gains(logic [GAIN_W-1:0] p, logic [GAIN_W-1:0] i,
                            logic [GAIN_W-1:0] d);
      write_gain(CSR_GAIN_P, p);
      write_gain(CSR_GAIN_I, i);
      write_gain(CSR_GAIN_D, d);
      gain_settings++;
   endtask

   // gains are zero out of reset, so every command must be zero
   task automatic test_reset_state();
      send_tick(16'sd0, 16'sd0);
      send_tick(16'h7FFF, 16'h8000);
      send_tick(16'h8000, 16'h7FFF);
      send_tick(16'sd0, 16'sd0);
      drain_results();
   endtask

   task automatic test_directed_ticks();
      set_gains(7'd3, 7'd127, 7'd5);
      send_tick(16'sd0, 16'sd0);
      send_tick(16'sd0, 16'sd1);
      send_tick(16'sd0, 16'sd2);        // odd negative total, halving rounds down
      send_tick(16'h7FFF, 16'h8000);    // largest error, stored wrapped to -1
      send_tick(16'sd100, 16'sd100);    // derivative sees the wrapped error
      send_tick(16'h8000, 16'h7FFF);    // most negative error, stored as +1
      send_tick(16'sd5, 16'sd5);
      send_tick(16'sd1000, 16'sd900);   // hold the target: integrator builds
      send_tick(16'sd1000, 16'sd900);
      send_tick(16'sd1000, 16'sd900);
      send_tick(16'sd1000, 16'sd900);
      send_tick(-16'sd1000, -16'sd900); // target change clears, negative sum truncates
      send_tick(-16'sd1000, -16'sd900);
      send_tick(-16'sd1000, -16'sd900);
      send_tick(16'hFFFF, 16'sd0);
      send_tick(16'sd0, 16'hFFFF);
      send_tick(16'h8000, 16'h8000);
      send_tick(16'h7FFF, 16'h7FFF);
      drain_results();
   endtask

   task automatic test_gain_extremes();
      set_gains(7'd127, 7'd127, 7'd127);
      send_tick(16'h7FFF, 16'h8000);
      send_tick(16'h8000, 16'h7FFF);
      send_tick(16'sd3, 16'sd2);
      drain_results();
      set_gains(7'd0, 7'd127, 7'd0);
      send_tick(16'sd50, 16'sd40);
      send_tick(16'sd50, 16'sd40);
      send_tick(16'sd50, 16'sd40);
      drain_results();
   endtask

   // a write beyond the last register must leave every gain alone
   task automatic test_unused_index();
      set_gains(7'd2, 7'd9, 7'd4);
      write_gain(CSR_UNUSED, 7'h7F);
      send_tick(16'sd200, 16'sd150);
      send_tick(16'sd200, 16'sd260);
      send_tick(-16'sd40, 16'sd10);
      drain_results();
   endtask

   // runs of ticks at one target with the measurement near it, plus noise ticks
   task automatic test_random_ticks(int count);
      int                 sent;
      int                 run_len;
      int                 delta;
      logic [SPEED_W-1:0] target;
      logic [SPEED_W-1:0] measured;
      sent = 0;
      while (sent < count) begin
         src_steady = ($urandom_range(0, 6) == 0);
         if ($urandom_range(0, 9) == 0) begin
            send_tick(SPEED_W'($urandom), SPEED_W'($urandom));
            sent++;
         end else begin
            case ($urandom_range(0, 3))
               0: target = SPEED_W'($urandom);
               1: target = SPEED_W'($urandom_range(0, 4000) - 2000);
               2: begin
                  case ($urandom_range(0, 3))
                     0: target = 16'h7FFF;
                     1: target = 16'h8000;
                     2: target = 16'h0000;
                     default: target = 16'hFFFF;
                  endcase
               end
               default: target = SPEED_W'($urandom_range(0, 24000) - 12000);
            endcase
            run_len = $urandom_range(1, 40);
            for (int k = 0; k < run_len && sent < count; k++) begin
               if ($urandom_range(0, 99) < 75) begin
                  delta    = $urandom_range(0, 600) - 300;
                  measured = target - delta[SPEED_W-1:0];
               end else begin
                  measured = SPEED_W'($urandom);
               end
               send_tick(target, measured);
               sent++;
            end
         end
      end
      src_steady = 1'b0;
      drain_results();
   endtask

   // hold the response side off while ticks keep coming, so the input stalls
   task automatic test_output_backpressure();
      set_gains(GAIN_W'($urandom_range(0, 127)), GAIN_W'($urandom_range(0, 127)),
                GAIN_W'($urandom_range(0, 127)));
      long_hold_ask <= long_hold_ask + 1;
      src_steady = 1'b1;
      for (int k = 0; k < 40; k++)
         send_tick(16'sd1234, SPEED_W'($urandom_range(1000, 1500)));
      src_steady = 1'b0;
      drain_results();
   endtask

   // response side: ready pattern and result checking
   int hold_left   = 0;
   int stall_left  = 0;
   int steady_left = 0;
   int hold_seen   = 0;

   always @(posedge clock) begin : rsp_side
      tick_result_type want;
      int              r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pwm_expected.size() == 0) begin
            report_mismatch($sformatf("drive_pwm %0d with no tick pending",
                                      $signed(rsp_tdata[PWM_W-1:0])));
         end else begin
            want = pwm_expected.pop_front();
            results_checked++;
            if (rsp_tdata[PWM_W-1:0] !== want.pwm)
               report_mismatch($sformatf("target %0d measured %0d: drive_pwm %0d, want %0d",
                                         $signed(want.target), $signed(want.measured),
                                         $signed(rsp_tdata[PWM_W-1:0]), $signed(want.pwm)));
            if (rsp_tdata[RSP_DATA_W-1:PWM_W] !== '0)
               report_mismatch($sformatf("rsp_tdata pad bits %b not zero",
                                         rsp_tdata[RSP_DATA_W-1:PWM_W]));
         end
      end
      if (long_hold_ask != hold_seen) begin
         hold_seen  <= long_hold_ask;
         hold_left  <= LONG_HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (steady_left > 0) begin
         steady_left <= steady_left - 1;
         rsp_tready  <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 5) steady_left <= $urandom_range(30, 120);
         else if (r < 30) stall_left <= pick_gap();
         rsp_tready <= !(r >= 5 && r < 30);
      end
   end

   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no beat for %0d cycles, %0d results pending",
                     IDLE_LIMIT, pwm_expected.size());
            $display("FAIL pid_speed_controller_top");
            $finish;
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_directed_ticks();
      test_gain_extremes();
      test_unused_index();
      set_gains(7'd127, 7'd127, 7'd127);
      test_random_ticks(200);
      set_gains(7'd1, 7'd1, 7'd1);
      test_random_ticks(150);
      set_gains(GAIN_W'($urandom_range(0, 127)), GAIN_W'($urandom_range(0, 127)),
                GAIN_W'($urandom_range(0, 127)));
      test_random_ticks(200);
      set_gains(GAIN_W'($urandom_range(0, 15)), GAIN_W'($urandom_range(0, 127)),
                GAIN_W'($urandom_range(0, 15)));
      test_random_ticks(220);
      test_output_backpressure();
      if (pwm_expected.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pwm_expected.size()));
      $display("covered %0d ticks and %0d drive commands over %0d gain settings",
               ticks_sent, results_checked, gain_settings);
      $display("incl. integrator clear, wrapped error, halving, clamp, output hold-off");
      if (error_count == 0) begin
         $display("PASS pid_speed_controller_top");
      end else begin
         $display("FAIL pid_speed_controller_top");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> sim.f
hw/rtl/pidsc_pkg.sv
hw/rtl/pid_speed_controller_top.sv
bench/pid_speed_controller_top_tb.sv
